FILE: design/ams_pkg.sv
// Shared types, codes and helpers for the accumulator machine.
// No dependencies; used by the top level and the checker.
package ams_pkg;

    localparam int DEF_MEM_DEPTH = 256;

    // Function codes of an input request
    localparam logic [1:0] FN_WRITE   = 2'd0;
    localparam logic [1:0] FN_EXEC    = 2'd1;
    localparam logic [1:0] FN_RESTART = 2'd2;

    // Result kinds
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PRINT = 2'd1;
    localparam logic [1:0] KIND_NL    = 2'd2;

    // Status codes
    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_HALT    = 3'd1;
    localparam logic [2:0] ST_OVER    = 3'd2;
    localparam logic [2:0] ST_UNDER   = 3'd3;
    localparam logic [2:0] ST_DIVZ    = 3'd4;
    localparam logic [2:0] ST_BADOP   = 3'd5;
    localparam logic [2:0] ST_STOPPED = 3'd6;

    // Opcodes (bits 15:8 of an instruction word)
    localparam logic [7:0] OP_READ    = 8'h0A;
    localparam logic [7:0] OP_WRITE   = 8'h0B;
    localparam logic [7:0] OP_RDSTR   = 8'h0C;
    localparam logic [7:0] OP_PRSTR   = 8'h0D;
    localparam logic [7:0] OP_NEWLINE = 8'h0E;
    localparam logic [7:0] OP_LOAD    = 8'h14;
    localparam logic [7:0] OP_STORE   = 8'h15;
    localparam logic [7:0] OP_ADD     = 8'h1E;
    localparam logic [7:0] OP_SUB     = 8'h1F;
    localparam logic [7:0] OP_DIV     = 8'h20;
    localparam logic [7:0] OP_MUL     = 8'h21;
    localparam logic [7:0] OP_REM     = 8'h22;
    localparam logic [7:0] OP_POW     = 8'h23;
    localparam logic [7:0] OP_BRANCH  = 8'h28;
    localparam logic [7:0] OP_BRNEG   = 8'h29;
    localparam logic [7:0] OP_BRZERO  = 8'h30;
    localparam logic [7:0] OP_HALT    = 8'h31;

    localparam int LIMIT_HI = 65535;

    // Reduce an 8-bit address modulo a depth of at least 16: the quotient
    // is below 16, so four compare-subtract steps suffice.
    function automatic logic [7:0] f_mod_depth(input logic [7:0] a, input int depth);
        logic [11:0] r;
        logic [11:0] d;
        r = {4'b0, a};
        for (int k = 3; k >= 0; k--) begin
            d = 12'(depth << k);
            if (r >= d) begin
                r = r - d;
            end
        end
        return r[7:0];
    endfunction

endpackage

FILE: design/ams_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module ams_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_q <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_q;

endmodule

FILE: design/accumulator_machine_step.sv
// Accumulator machine: word memory in ams_ram, pc, accumulator, halt flag.
// Write, restart and stopped-execute requests go straight to a registered result;
// execute steps through fetch read, operand read, execute and result; multiply,
// divide/remainder and power loop through extra states. One request at a time.
// Reset (i_rst_n low, synchronous) clears pc, accumulator, halt and all
// memory valid bits, so every word reads as zero until written.
module accumulator_machine_step
    import ams_pkg::*;
#(
    parameter int MEM_DEPTH = DEF_MEM_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [1:0]  i_func,
    input  logic [7:0]  i_address,
    input  logic [31:0] i_data,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [1:0]  o_kind,
    output logic [31:0] o_value,
    output logic [7:0]  o_program_counter_out,
    output logic [31:0] o_accumulator_out,
    output logic        o_halted,
    output logic [2:0]  o_status
);

    localparam int AW = $clog2(MEM_DEPTH);

    // One-hot sequencer states
    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_FETCH = 11'b00000000010,
        S_OPND  = 11'b00000000100,
        S_EXEC  = 11'b00000001000,
        S_MUL   = 11'b00000010000,
        S_MULC  = 11'b00000100000,
        S_DIV   = 11'b00001000000,
        S_DIVF  = 11'b00010000000,
        S_POWR  = 11'b00100000000,
        S_POWB  = 11'b01000000000,
        S_DONE  = 11'b10000000000
    } t_state;

    t_state r_state, n_state;

    // Architectural state
    logic [AW-1:0] r_pc, n_pc;
    logic [31:0]   r_acc, n_acc;
    logic          r_stopped, n_stopped;
    logic [MEM_DEPTH-1:0] r_wvalid, n_wvalid;
    logic          r_rd_ok, n_rd_ok;

    // Per-request working registers
    logic [31:0]   r_data, n_data;
    logic [31:0]   r_word, n_word;
    logic [AW-1:0] r_opa, n_opa;
    logic [31:0]   r_m, n_m;
    logic [1:0]    r_kind, n_kind;
    logic [31:0]   r_value, n_value;
    logic [2:0]    r_status, n_status;
    logic [63:0]   r_prod, n_prod;
    logic [31:0]   r_pres, n_pres;
    logic [31:0]   r_base, n_base;
    logic [30:0]   r_exp, n_exp;
    logic [31:0]   r_dvd, n_dvd;
    logic [31:0]   r_dvs, n_dvs;
    logic [31:0]   r_rem, n_rem;
    logic [4:0]    r_cnt, n_cnt;
    logic          r_qneg, n_qneg;
    logic          r_rneg, n_rneg;

    // Output register
    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_o_kind, n_o_kind;
    logic [31:0]   r_o_value, n_o_value;
    logic [AW-1:0] r_o_pc, n_o_pc;
    logic [31:0]   r_o_acc, n_o_acc;
    logic          r_o_halted, n_o_halted;
    logic [2:0]    r_o_status, n_o_status;

    // Memory port
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [31:0]   ram_wd, ram_q;

    ams_ram #(
        .WIDTH (32),
        .DEPTH (MEM_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_wa),
        .i_wdata (ram_wd),
        .i_re    (ram_re),
        .i_raddr (ram_ra),
        .o_rdata (ram_q)
    );

    // Datapath helpers
    logic [31:0]        word_q;
    logic [AW-1:0]      fetch_opa;
    logic [AW-1:0]      pc_next;
    logic [32:0]        sum33, diff33;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] mul_p;
    logic [32:0]        rem_sh, rem_sub;
    logic               rem_ge;
    logic [31:0]        acc_abs, m_abs, q_fin, rem_fin;
    logic               ex_stop, ex_defer, ex_jump;
    logic [2:0]         ex_status;

    // An entry never written since reset reads as zero
    assign word_q    = r_rd_ok ? ram_q : '0;
    assign fetch_opa = AW'(f_mod_depth(word_q[7:0], MEM_DEPTH));
    assign pc_next   = (r_pc == AW'(MEM_DEPTH - 1)) ? '0 : r_pc + 1'b1;

    assign sum33  = {r_acc[31], r_acc} + {r_m[31], r_m};
    assign diff33 = {r_acc[31], r_acc} - {r_m[31], r_m};

    // Shared multiplier: accumulator times operand, or the power loop
    always_comb begin
        case (r_state)
            S_POWB: begin
                mul_a = $signed(r_base);
                mul_b = $signed(r_base);
            end
            S_POWR: begin
                mul_a = $signed(r_pres);
                mul_b = $signed(r_base);
            end
            default: begin
                mul_a = $signed(r_acc);
                mul_b = $signed(r_m);
            end
        endcase
    end
    assign mul_p = mul_a * mul_b;

    // Restoring divider step on magnitudes; quotient shifts into r_dvd
    assign rem_sh  = {r_rem, r_dvd[31]};
    assign rem_sub = rem_sh - {1'b0, r_dvs};
    assign rem_ge  = ~rem_sub[32];
    assign acc_abs = r_acc[31] ? 32'(-r_acc) : r_acc;
    assign m_abs   = r_m[31] ? 32'(-r_m) : r_m;
    assign q_fin   = r_qneg ? 32'(-r_dvd) : r_dvd;
    assign rem_fin = r_rneg ? 32'(-r_rem) : r_rem;

    always_comb begin
        n_state     = r_state;
        n_pc        = r_pc;
        n_acc       = r_acc;
        n_stopped   = r_stopped;
        n_wvalid    = r_wvalid;
        n_rd_ok     = r_rd_ok;
        n_data      = r_data;
        n_word      = r_word;
        n_opa       = r_opa;
        n_m         = r_m;
        n_kind      = r_kind;
        n_value     = r_value;
        n_status    = r_status;
        n_prod      = r_prod;
        n_pres      = r_pres;
        n_base      = r_base;
        n_exp       = r_exp;
        n_dvd       = r_dvd;
        n_dvs       = r_dvs;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_qneg      = r_qneg;
        n_rneg      = r_rneg;
        n_out_valid = r_out_valid & ~i_out_ready;
        n_o_kind    = r_o_kind;
        n_o_value   = r_o_value;
        n_o_pc      = r_o_pc;
        n_o_acc     = r_o_acc;
        n_o_halted  = r_o_halted;
        n_o_status  = r_o_status;
        ram_we      = 1'b0;
        ram_wa      = '0;
        ram_wd      = '0;
        ram_re      = 1'b0;
        ram_ra      = '0;
        ex_stop     = 1'b0;
        ex_defer    = 1'b0;
        ex_jump     = 1'b0;
        ex_status   = ST_OK;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_kind   = KIND_NONE;
                    n_value  = '0;
                    n_status = ST_OK;
                    n_data   = i_data;
                    n_state  = S_DONE;
                    case (i_func)
                        FN_WRITE: begin
                            ram_we = 1'b1;
                            ram_wa = AW'(f_mod_depth(i_address, MEM_DEPTH));
                            ram_wd = i_data;
                        end
                        FN_EXEC: begin
                            if (r_stopped) begin
                                n_status = ST_STOPPED;
                            end else begin
                                ram_re  = 1'b1;
                                ram_ra  = r_pc;
                                n_state = S_FETCH;
                            end
                        end
                        FN_RESTART: begin
                            n_pc      = '0;
                            n_acc     = '0;
                            n_stopped = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            S_FETCH: begin
                n_word  = word_q;
                n_opa   = fetch_opa;
                ram_re  = 1'b1;
                ram_ra  = fetch_opa;
                n_state = S_OPND;
            end
            S_OPND: begin
                n_m     = word_q;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_DONE;
                if (r_word[31:16] != '0) begin
                    ex_stop   = 1'b1;
                    ex_status = ST_BADOP;
                end else begin
                    case (r_word[15:8])
                        OP_READ: begin
                            ram_we = 1'b1;
                            ram_wa = r_opa;
                            ram_wd = r_data;
                        end
                        OP_WRITE: begin
                            n_kind  = KIND_PRINT;
                            n_value = r_m;
                        end
                        OP_RDSTR, OP_PRSTR: ;
                        OP_NEWLINE: n_kind = KIND_NL;
                        OP_LOAD:    n_acc = r_m;
                        OP_STORE: begin
                            ram_we = 1'b1;
                            ram_wa = r_opa;
                            ram_wd = r_acc;
                        end
                        OP_ADD: begin
                            if ($signed(sum33) > 33'sd65535) begin
                                ex_stop   = 1'b1;
                                ex_status = ST_OVER;
                            end else begin
                                n_acc = sum33[31:0];
                            end
                        end
                        OP_SUB: begin
                            if ($signed(diff33) < -33'sd65535) begin
                                ex_stop   = 1'b1;
                                ex_status = ST_UNDER;
                            end else begin
                                n_acc = diff33[31:0];
                            end
                        end
                        OP_MUL: begin
                            ex_defer = 1'b1;
                            n_state  = S_MUL;
                        end
                        OP_DIV, OP_REM: begin
                            if (r_m == '0) begin
                                ex_stop   = 1'b1;
                                ex_status = ST_DIVZ;
                            end else begin
                                ex_defer = 1'b1;
                                n_dvd    = acc_abs;
                                n_dvs    = m_abs;
                                n_rem    = '0;
                                n_cnt    = '0;
                                n_qneg   = r_acc[31] ^ r_m[31];
                                n_rneg   = r_acc[31];
                                n_state  = S_DIV;
                            end
                        end
                        OP_POW: begin
                            if (!r_m[31] && (r_m[30:1] != '0)) begin
                                ex_defer = 1'b1;
                                n_pres   = 32'd1;
                                n_base   = r_acc;
                                n_exp    = r_m[30:0];
                                n_state  = S_POWR;
                            end
                        end
                        OP_BRANCH:  ex_jump = 1'b1;
                        OP_BRNEG:   ex_jump = r_acc[31];
                        OP_BRZERO:  ex_jump = (r_acc == '0);
                        OP_HALT: begin
                            ex_stop   = 1'b1;
                            ex_status = ST_HALT;
                        end
                        default: begin
                            ex_stop   = 1'b1;
                            ex_status = ST_BADOP;
                        end
                    endcase
                end
                if (ex_stop) begin
                    n_stopped = 1'b1;
                    n_status  = ex_status;
                end else if (!ex_defer) begin
                    n_pc = ex_jump ? r_opa : pc_next;
                end
            end
            S_MUL: begin
                n_prod  = mul_p;
                n_state = S_MULC;
            end
            S_MULC: begin
                n_state = S_DONE;
                if ($signed(r_prod) > 64'sd65535) begin
                    n_stopped = 1'b1;
                    n_status  = ST_OVER;
                end else begin
                    n_acc = r_prod[31:0];
                    n_pc  = pc_next;
                end
            end
            S_DIV: begin
                n_rem = rem_ge ? rem_sub[31:0] : rem_sh[31:0];
                n_dvd = {r_dvd[30:0], rem_ge};
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == '1) begin
                    n_state = S_DIVF;
                end
            end
            S_DIVF: begin
                n_acc   = (r_word[15:8] == OP_DIV) ? q_fin : rem_fin;
                n_pc    = pc_next;
                n_state = S_DONE;
            end
            S_POWR: begin
                if (r_exp == '0) begin
                    n_acc   = r_pres;
                    n_pc    = pc_next;
                    n_state = S_DONE;
                end else begin
                    if (r_exp[0]) begin
                        n_pres = mul_p[31:0];
                    end
                    n_state = S_POWB;
                end
            end
            S_POWB: begin
                n_base  = mul_p[31:0];
                n_exp   = r_exp >> 1;
                n_state = S_POWR;
            end
            S_DONE: begin
                // Hold the result until the output register is free
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_o_kind    = r_kind;
                    n_o_value   = r_value;
                    n_o_pc      = r_pc;
                    n_o_acc     = r_acc;
                    n_o_halted  = r_stopped;
                    n_o_status  = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (ram_we) begin
            n_wvalid[ram_wa] = 1'b1;
        end
        if (ram_re) begin
            n_rd_ok = r_wvalid[ram_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_acc       <= '0;
            r_stopped   <= 1'b0;
            r_wvalid    <= '0;
            r_rd_ok     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pc        <= n_pc;
            r_acc       <= n_acc;
            r_stopped   <= n_stopped;
            r_wvalid    <= n_wvalid;
            r_rd_ok     <= n_rd_ok;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data     <= n_data;
        r_word     <= n_word;
        r_opa      <= n_opa;
        r_m        <= n_m;
        r_kind     <= n_kind;
        r_value    <= n_value;
        r_status   <= n_status;
        r_prod     <= n_prod;
        r_pres     <= n_pres;
        r_base     <= n_base;
        r_exp      <= n_exp;
        r_dvd      <= n_dvd;
        r_dvs      <= n_dvs;
        r_rem      <= n_rem;
        r_cnt      <= n_cnt;
        r_qneg     <= n_qneg;
        r_rneg     <= n_rneg;
        r_o_kind   <= n_o_kind;
        r_o_value  <= n_o_value;
        r_o_pc     <= n_o_pc;
        r_o_acc    <= n_o_acc;
        r_o_halted <= n_o_halted;
        r_o_status <= n_o_status;
    end

    assign o_in_ready            = (r_state == S_IDLE);
    assign o_out_valid           = r_out_valid;
    assign o_kind                = r_o_kind;
    assign o_value               = r_o_value;
    assign o_program_counter_out = 8'(r_o_pc);
    assign o_accumulator_out     = r_o_acc;
    assign o_halted              = r_o_halted;
    assign o_status              = r_o_status;

endmodule

FILE: design/ams_chk.sv
// Port-level checker for the accumulator machine, bound to the top level.
// Depends on ams_pkg for result kinds and status codes.
module ams_chk
    import ams_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [1:0]  o_kind,
    input logic [31:0] o_value,
    input logic        o_halted,
    input logic [2:0]  o_status
);

    // A stalled result holds its payload
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_value) && $stable(o_status))
        else $error("result changed while stalled");

    // Value is only carried by a write instruction
    a_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_PRINT) |-> (o_value == '0))
        else $error("value set without print kind");

    // Any stop status leaves the machine halted
    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_OK) |-> o_halted)
        else $error("stop status without halt");

    // Printed output only comes from a successful instruction
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_kind != KIND_NONE) |-> (o_status == ST_OK) && !o_halted)
        else $error("output kind with failing status");

endmodule

bind accumulator_machine_step ams_chk u_ams_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_kind      (o_kind),
    .o_value     (o_value),
    .o_halted    (o_halted),
    .o_status    (o_status)
);
